[rtl/ssns_pkg.sv]
`default_nettype none

package ssns_pkg;

   localparam int DEFAULT_VALUE_BITS = 16;
   localparam int DEFAULT_COORD_BITS = 16;
   localparam int SCALE_BITS         = 12;
   localparam int BCD_W              = 4;
   localparam int SEG_COUNT          = 7;
   localparam int SEG_IDX_W          = 3;
   localparam int GLYPH_UNIT_W       = 5;

   // Pen and stroke geometry in glyph units
   localparam int MINUS_PEN  = 14;
   localparam int DIGIT_PEN  = 18;
   localparam int MINUS_Y    = 10;
   localparam int MINUS_LEN  = 8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_DRAW
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic advance;
   } bcd_ctl_type;

   typedef struct packed {
      logic [GLYPH_UNIT_W-1:0] x0;
      logic [GLYPH_UNIT_W-1:0] y0;
      logic [GLYPH_UNIT_W-1:0] x1;
      logic [GLYPH_UNIT_W-1:0] y1;
   } seg_ends_type;

   // Bit s lit means segment s (top first, bottom last)
   function automatic logic [SEG_COUNT-1:0] glyph_mask(input logic [BCD_W-1:0] digit);
      logic [SEG_COUNT-1:0] mask;
      unique case (digit)
         4'd0: mask = 7'h77;
         4'd1: mask = 7'h24;
         4'd2: mask = 7'h5D;
         4'd3: mask = 7'h6D;
         4'd4: mask = 7'h2E;
         4'd5: mask = 7'h6B;
         4'd6: mask = 7'h7B;
         4'd7: mask = 7'h25;
         4'd8: mask = 7'h7F;
         4'd9: mask = 7'h6F;
         default: mask = '0;
      endcase
      return mask;
   endfunction

   function automatic seg_ends_type seg_ends(input logic [SEG_IDX_W-1:0] seg);
      seg_ends_type e;
      unique case (seg)
         3'd0: e = '{x0: 5'd0,  y0: 5'd20, x1: 5'd12, y1: 5'd20};
         3'd1: e = '{x0: 5'd0,  y0: 5'd20, x1: 5'd0,  y1: 5'd10};
         3'd2: e = '{x0: 5'd12, y0: 5'd20, x1: 5'd12, y1: 5'd10};
         3'd3: e = '{x0: 5'd0,  y0: 5'd10, x1: 5'd12, y1: 5'd10};
         3'd4: e = '{x0: 5'd0,  y0: 5'd10, x1: 5'd0,  y1: 5'd0};
         3'd5: e = '{x0: 5'd12, y0: 5'd10, x1: 5'd12, y1: 5'd0};
         3'd6: e = '{x0: 5'd0,  y0: 5'd0,  x1: 5'd12, y1: 5'd0};
         default: e = '0;
      endcase
      return e;
   endfunction

endpackage

`default_nettype wire

[rtl/ssns_if.sv]
`default_nettype none

interface ssns_req_if #(
   parameter int VALUE_BITS = ssns_pkg::DEFAULT_VALUE_BITS,
   parameter int COORD_BITS = ssns_pkg::DEFAULT_COORD_BITS
);
   logic                             valid;
   logic                             ready;
   logic [VALUE_BITS-1:0]            value;
   logic [COORD_BITS-1:0]            origin_x;
   logic [COORD_BITS-1:0]            origin_y;
   logic [ssns_pkg::SCALE_BITS-1:0]  scale;

   modport source (output valid, value, origin_x, origin_y, scale, input ready);
   modport sink   (input valid, value, origin_x, origin_y, scale, output ready);
endinterface

interface ssns_rsp_if #(
   parameter int COORD_BITS = ssns_pkg::DEFAULT_COORD_BITS
);
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] start_x;
   logic [COORD_BITS-1:0] start_y;
   logic [COORD_BITS-1:0] end_x;
   logic [COORD_BITS-1:0] end_y;
   logic                  last;

   modport source (output valid, start_x, start_y, end_x, end_y, last, input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, last, output ready);
endinterface

`default_nettype wire

[rtl/ssns_bcd.sv]
`default_nettype none

// Bit-serial binary to BCD (shift and add three), then a digit shifter
// that presents digits most significant first.
module ssns_bcd #(
   parameter int VALUE_BITS = ssns_pkg::DEFAULT_VALUE_BITS,
   parameter int NUM_DIGITS = 5
) (
   input  wire logic                         clock,
   input  wire ssns_pkg::bcd_ctl_type        ctl,
   input  wire logic [VALUE_BITS-1:0]        mag,
   output      logic [ssns_pkg::BCD_W-1:0]   top_digit,
   output      logic [ssns_pkg::BCD_W-1:0]   next_digit
);

   localparam int BcdW = NUM_DIGITS * ssns_pkg::BCD_W;

   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [BcdW-1:0]       bcd_ff, bcd_in;
   logic [BcdW-1:0]       bcd_adj;

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i*ssns_pkg::BCD_W +: ssns_pkg::BCD_W] >= 4'd5) begin
            bcd_adj[i*ssns_pkg::BCD_W +: ssns_pkg::BCD_W] =
               bcd_ff[i*ssns_pkg::BCD_W +: ssns_pkg::BCD_W] + 4'd3;
         end else begin
            bcd_adj[i*ssns_pkg::BCD_W +: ssns_pkg::BCD_W] =
               bcd_ff[i*ssns_pkg::BCD_W +: ssns_pkg::BCD_W];
         end
      end
   end

   always_comb begin
      mag_in = mag_ff;
      bcd_in = bcd_ff;
      if (ctl.load) begin
         mag_in = mag;
         bcd_in = '0;
      end else if (ctl.step) begin
         mag_in = {mag_ff[VALUE_BITS-2:0], 1'b0};
         bcd_in = {bcd_adj[BcdW-2:0], mag_ff[VALUE_BITS-1]};
      end else if (ctl.advance) begin
         bcd_in = {bcd_ff[BcdW-ssns_pkg::BCD_W-1:0], {ssns_pkg::BCD_W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
   end

   assign top_digit  = bcd_ff[BcdW-1 -: ssns_pkg::BCD_W];
   assign next_digit = bcd_ff[BcdW-ssns_pkg::BCD_W-1 -: ssns_pkg::BCD_W];

endmodule

`default_nettype wire

[rtl/seven_segment_number_strokes_core.sv]
// Seven-segment number stroke generator.
// req_bus (sink): one word carries value (signed), origin_x/origin_y (signed
// fixed point, 4 fraction bits) and scale (unsigned, 8 fraction bits).
// rsp_bus (source): one word per line segment, start_x/start_y/end_x/end_y
// saturated to the coordinate width, last set on the final segment.
// A negative value opens with a minus stroke; digits follow most
// significant first, each as its lit segments from top to bottom.
// Per word: the block takes it, runs bit-serial BCD conversion over all
// VALUE_BITS bits, drops leading zeros (up to NumDigits-1), loads the first
// glyph, then issues one segment per cycle while the receiver keeps the
// output register free (2 to 1+7*digits segments; 36 at most for 16-bit
// values). req_bus.ready is high only while idle; the next word is
// taken the cycle after the last segment enters the output register, even
// while that segment still waits to be taken.
// A stalled receiver holds the output register and freezes the segment
// walk. Synchronous reset empties the output register and returns to idle.
`default_nettype none

module seven_segment_number_strokes_core #(
   parameter int VALUE_BITS = ssns_pkg::DEFAULT_VALUE_BITS,
   parameter int COORD_BITS = ssns_pkg::DEFAULT_COORD_BITS
) (
   input wire logic  clock,
   input wire logic  reset,
   ssns_req_if.sink  req_bus,
   ssns_rsp_if.source rsp_bus
);

   // Enough decimal digits for 2^(VALUE_BITS-1)
   localparam int NumDigits = (VALUE_BITS * 3) / 10 + 1;
   localparam int BitCntW   = $clog2(VALUE_BITS);
   localparam int DigCntW   = $clog2(NumDigits);
   // Widest x offset: minus pen, all digit advances, one cell width
   localparam int MaxUnits  = ssns_pkg::MINUS_PEN + ssns_pkg::DIGIT_PEN * (NumDigits - 1) + 12;
   localparam int UnitBits  = $clog2(MaxUnits + 1);
   localparam int ProdW     = UnitBits + ssns_pkg::SCALE_BITS;
   localparam int OffW      = ProdW - 3;
   localparam int SumW      = ((OffW > COORD_BITS) ? OffW : COORD_BITS) + 2;

   // origin + round(units*scale/16), saturated
   function automatic logic [COORD_BITS-1:0] place(
      input logic [COORD_BITS-1:0]           org,
      input logic [UnitBits-1:0]             units,
      input logic [ssns_pkg::SCALE_BITS-1:0] scl
   );
      logic [ProdW:0]            prod;
      logic [SumW-1:0]           sum;
      logic [SumW-COORD_BITS:0]  upper;
      logic [COORD_BITS-1:0]     res;
      prod  = (ProdW+1)'(units) * (ProdW+1)'(scl) + (ProdW+1)'(8);
      sum   = {{(SumW-COORD_BITS){org[COORD_BITS-1]}}, org}
            + {{(SumW-OffW){1'b0}}, prod[ProdW:4]};
      upper = sum[SumW-1:COORD_BITS-1];
      if ((upper == '0) || (upper == '1)) begin
         res = sum[COORD_BITS-1:0];
      end else if (sum[SumW-1]) begin
         res = {1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
         res = {1'b0, {(COORD_BITS-1){1'b1}}};
      end
      return res;
   endfunction

   ssns_pkg::state_type state_ff, state_in;

   logic                              neg_ff, neg_in;
   logic [COORD_BITS-1:0]             origin_x_ff, origin_x_in;
   logic [COORD_BITS-1:0]             origin_y_ff, origin_y_in;
   logic [ssns_pkg::SCALE_BITS-1:0]   scale_ff, scale_in;
   logic [BitCntW-1:0]                bit_cnt_ff, bit_cnt_in;
   logic [DigCntW-1:0]                dig_cnt_ff, dig_cnt_in;
   logic [UnitBits-1:0]               pen_ff, pen_in;
   logic [ssns_pkg::SEG_COUNT-1:0]    mask_ff, mask_in;
   logic                              minus_ff, minus_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0]             start_x_ff, start_x_in;
   logic [COORD_BITS-1:0]             start_y_ff, start_y_in;
   logic [COORD_BITS-1:0]             end_x_ff, end_x_in;
   logic [COORD_BITS-1:0]             end_y_ff, end_y_in;
   logic                              last_ff, last_in;

   ssns_pkg::bcd_ctl_type             bcd_ctl;
   logic [ssns_pkg::BCD_W-1:0]        top_digit, next_digit;
   logic [VALUE_BITS-1:0]             mag;

   logic                              req_take;
   logic                              slot_free;
   logic                              issue;
   logic                              skip_zero;
   logic                              digit_done;
   logic                              final_seg;
   logic [ssns_pkg::SEG_IDX_W-1:0]    seg_idx;
   logic [ssns_pkg::SEG_COUNT-1:0]    mask_rest;
   ssns_pkg::seg_ends_type            ends;
   logic [UnitBits-1:0]               sx_u, sy_u, ex_u, ey_u;

   // Magnitude of the value; the most negative value maps to 2^(VALUE_BITS-1)
   assign mag = req_bus.value[VALUE_BITS-1] ? (~req_bus.value + VALUE_BITS'(1))
                                            : req_bus.value;

   ssns_bcd #(
      .VALUE_BITS (VALUE_BITS),
      .NUM_DIGITS (NumDigits)
   ) u_bcd (
      .clock      (clock),
      .ctl        (bcd_ctl),
      .mag        (mag),
      .top_digit  (top_digit),
      .next_digit (next_digit)
   );

   // Lowest lit segment goes first; it is cleared from the mask once issued
   always_comb begin
      seg_idx = '0;
      for (int i = ssns_pkg::SEG_COUNT - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            seg_idx = ssns_pkg::SEG_IDX_W'(i);
         end
      end
   end

   assign mask_rest = mask_ff & (mask_ff - ssns_pkg::SEG_COUNT'(1));
   assign ends      = ssns_pkg::seg_ends(seg_idx);
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign skip_zero = (top_digit == '0) && (dig_cnt_ff != '0);

   // Outputs of the sequencer
   always_comb begin
      req_bus.ready = 1'b0;
      issue         = 1'b0;
      bcd_ctl       = '0;
      unique case (state_ff)
         ssns_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
            bcd_ctl.load  = req_bus.valid;
         end
         ssns_pkg::ST_CONVERT: begin
            bcd_ctl.step = 1'b1;
         end
         ssns_pkg::ST_SKIP: begin
            bcd_ctl.advance = skip_zero;
         end
         ssns_pkg::ST_DRAW: begin
            issue           = slot_free;
            bcd_ctl.advance = digit_done && !final_seg;
         end
         default: begin
            req_bus.ready = 1'b0;
         end
      endcase
   end

   assign req_take   = req_bus.valid && req_bus.ready;
   assign digit_done = issue && !minus_ff && (mask_rest == '0);
   assign final_seg  = digit_done && (dig_cnt_ff == '0);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ssns_pkg::ST_IDLE: begin
            if (req_bus.valid) state_in = ssns_pkg::ST_CONVERT;
         end
         ssns_pkg::ST_CONVERT: begin
            if (bit_cnt_ff == '0) state_in = ssns_pkg::ST_SKIP;
         end
         ssns_pkg::ST_SKIP: begin
            if (!skip_zero) state_in = ssns_pkg::ST_DRAW;
         end
         ssns_pkg::ST_DRAW: begin
            if (final_seg) state_in = ssns_pkg::ST_IDLE;
         end
         default: begin
            state_in = ssns_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath registers of the walk
   always_comb begin
      neg_in      = neg_ff;
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      scale_in    = scale_ff;
      bit_cnt_in  = bit_cnt_ff;
      dig_cnt_in  = dig_cnt_ff;
      pen_in      = pen_ff;
      mask_in     = mask_ff;
      minus_in    = minus_ff;

      if (req_take) begin
         // latch the word and arm the conversion
         neg_in      = req_bus.value[VALUE_BITS-1];
         origin_x_in = req_bus.origin_x;
         origin_y_in = req_bus.origin_y;
         scale_in    = req_bus.scale;
         bit_cnt_in  = BitCntW'(VALUE_BITS - 1);
         dig_cnt_in  = DigCntW'(NumDigits - 1);
      end

      if (state_ff == ssns_pkg::ST_CONVERT) begin
         bit_cnt_in = bit_cnt_ff - BitCntW'(1);
      end

      if (state_ff == ssns_pkg::ST_SKIP) begin
         if (skip_zero) begin
            // drop a leading zero
            dig_cnt_in = dig_cnt_ff - DigCntW'(1);
         end else begin
            mask_in  = ssns_pkg::glyph_mask(top_digit);
            pen_in   = neg_ff ? UnitBits'(ssns_pkg::MINUS_PEN) : '0;
            minus_in = neg_ff;
         end
      end

      if (issue) begin
         if (minus_ff) begin
            minus_in = 1'b0;
         end else if (mask_rest != '0) begin
            mask_in = mask_rest;
         end else if (!final_seg) begin
            // advance to the next digit
            mask_in    = ssns_pkg::glyph_mask(next_digit);
            pen_in     = pen_ff + UnitBits'(ssns_pkg::DIGIT_PEN);
            dig_cnt_in = dig_cnt_ff - DigCntW'(1);
         end
      end
   end

   // Endpoint offsets in glyph units
   always_comb begin
      if (minus_ff) begin
         sx_u = '0;
         sy_u = UnitBits'(ssns_pkg::MINUS_Y);
         ex_u = UnitBits'(ssns_pkg::MINUS_LEN);
         ey_u = UnitBits'(ssns_pkg::MINUS_Y);
      end else begin
         sx_u = pen_ff + UnitBits'(ends.x0);
         sy_u = UnitBits'(ends.y0);
         ex_u = pen_ff + UnitBits'(ends.x1);
         ey_u = UnitBits'(ends.y1);
      end
   end

   // Output register: load on issue, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      start_x_in   = start_x_ff;
      start_y_in   = start_y_ff;
      end_x_in     = end_x_ff;
      end_y_in     = end_y_ff;
      last_in      = last_ff;
      if (issue) begin
         rsp_valid_in = 1'b1;
         start_x_in   = place(origin_x_ff, sx_u, scale_ff);
         start_y_in   = place(origin_y_ff, sy_u, scale_ff);
         end_x_in     = place(origin_x_ff, ex_u, scale_ff);
         end_y_in     = place(origin_y_ff, ey_u, scale_ff);
         last_in      = final_seg;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssns_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      origin_x_ff <= origin_x_in;
      origin_y_ff <= origin_y_in;
      scale_ff    <= scale_in;
      bit_cnt_ff  <= bit_cnt_in;
      dig_cnt_ff  <= dig_cnt_in;
      pen_ff      <= pen_in;
      mask_ff     <= mask_in;
      minus_ff    <= minus_in;
      start_x_ff  <= start_x_in;
      start_y_ff  <= start_y_in;
      end_x_ff    <= end_x_in;
      end_y_ff    <= end_y_in;
      last_ff     <= last_in;
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.start_x = start_x_ff;
   assign rsp_bus.start_y = start_y_ff;
   assign rsp_bus.end_x   = end_x_ff;
   assign rsp_bus.end_y   = end_y_ff;
   assign rsp_bus.last    = last_ff;

endmodule

`default_nettype wire

[rtl/ssns_checker.sv]
`default_nettype none

module ssns_checker #(
   parameter int COORD_BITS = ssns_pkg::DEFAULT_COORD_BITS
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [COORD_BITS-1:0] rsp_start_x,
   input wire logic [COORD_BITS-1:0] rsp_start_y,
   input wire logic [COORD_BITS-1:0] rsp_end_x,
   input wire logic [COORD_BITS-1:0] rsp_end_y,
   input wire logic                  rsp_last
);

   // Reset empties the output and returns to idle
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("output not empty or block not idle after reset");

   // A stalled segment word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_start_x) && $stable(rsp_start_y)
         && $stable(rsp_end_x) && $stable(rsp_end_y) && $stable(rsp_last))
      else $error("stalled segment word changed");

   // One number at a time
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new word taken while a number is in progress");

   // Segments before the last one belong to a number still being drawn
   a_mid_number_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("idle while a number has segments left");

endmodule

bind seven_segment_number_strokes_core ssns_checker #(
   .COORD_BITS (COORD_BITS)
) u_ssns_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_start_x (rsp_bus.start_x),
   .rsp_start_y (rsp_bus.start_y),
   .rsp_end_x   (rsp_bus.end_x),
   .rsp_end_y   (rsp_bus.end_y),
   .rsp_last    (rsp_bus.last)
);

`default_nettype wire

[tb/sv/testbench.sv]
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VW         = ssns_pkg::DEFAULT_VALUE_BITS;
   localparam int CW         = ssns_pkg::DEFAULT_COORD_BITS;
   localparam int SCALE_BITS = ssns_pkg::SCALE_BITS;
   localparam int COORD_MAX  = (1 << (CW - 1)) - 1;
   localparam int COORD_MIN  = -(1 << (CW - 1));

   // Glyph geometry, in glyph units, kept apart from the RTL's own tables
   localparam int PEN_AFTER_MINUS = 14;
   localparam int PEN_PER_DIGIT   = 18;
   localparam int BAR_HEIGHT      = 10;
   localparam int BAR_LENGTH      = 8;
   localparam int CELL_WIDTH      = 12;
   localparam int CELL_MID        = 10;
   localparam int CELL_TOP        = 20;

   localparam int RANDOM_WORDS      = 142;
   localparam int SINK_HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES      = 64;
   localparam int MAX_REPORTS       = 10;

   typedef enum int {
      SEG_TOP,
      SEG_UPPER_LEFT,
      SEG_UPPER_RIGHT,
      SEG_MIDDLE,
      SEG_LOWER_LEFT,
      SEG_LOWER_RIGHT,
      SEG_BOTTOM
   } segment_type;

   // Bit g set means segment g is lit for that digit
   localparam logic [6:0] LIT_SEGMENTS [10] = '{
      7'h77, 7'h24, 7'h5D, 7'h6D, 7'h2E, 7'h6B, 7'h7B, 7'h25, 7'h7F, 7'h6F
   };

   typedef struct packed {
      logic [CW-1:0] sx;
      logic [CW-1:0] sy;
      logic [CW-1:0] ex;
      logic [CW-1:0] ey;
      logic          last;
   } stroke_type;

   // One word on the request side, plus an optional hand-typed first stroke
   typedef struct packed {
      logic [VW-1:0]         value;
      logic [CW-1:0]         origin_x;
      logic [CW-1:0]         origin_y;
      logic [SCALE_BITS-1:0] scale;
      logic                  has_lead;
      stroke_type            lead;
   } word_type;

   localparam stroke_type NO_LEAD = '0;
   localparam int N_DIRECTED = 18;

   // Columns: value, origin_x, origin_y, scale, has_lead, first stroke
   localparam word_type DIRECTED_WORDS [N_DIRECTED] = '{
      // zero at unit scale
      '{16'h0000, 16'h0000, 16'h0000, 12'h100, 1'b0, NO_LEAD},
      // zero scale: every stroke collapses onto the origin
      '{16'h0000, 16'h0064, 16'hFF38, 12'h000, 1'b1,
        '{16'h0064, 16'hFF38, 16'h0064, 16'hFF38, 1'b0}},
      // minus one: minus bar first, 8 units long at height 10
      '{16'hFFFF, 16'h0000, 16'h0000, 12'h100, 1'b1,
        '{16'h0000, 16'h00A0, 16'h0080, 16'h00A0, 1'b0}},
      '{16'h7FFF, 16'h0000, 16'h0000, 12'h100, 1'b0, NO_LEAD},
      // most negative value: magnitude drawn exactly
      '{16'h8000, 16'h0000, 16'h0000, 12'h080, 1'b0, NO_LEAD},
      '{16'h8000, 16'h8000, 16'h8000, 12'h000, 1'b1,
        '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0}},
      // top stroke of an eight pinned at the positive coordinate limit
      '{16'h0008, 16'h7FF0, 16'h7FF0, 12'hFFF, 1'b1,
        '{16'h7FF0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0}},
      // smallest nonzero scale: half-up rounding of each offset
      '{16'h0001, 16'h0000, 16'h0000, 12'h001, 1'b1,
        '{16'h0001, 16'h0001, 16'h0001, 16'h0001, 1'b0}},
      '{16'h3039, 16'h0100, 16'h0200, 12'h040, 1'b0, NO_LEAD},
      '{16'h1A85, 16'hF000, 16'h0400, 12'h0C0, 1'b0, NO_LEAD},
      '{16'hFFF7, 16'h0000, 16'h0000, 12'h100, 1'b0, NO_LEAD},
      '{16'h000A, 16'h1000, 16'h1000, 12'h100, 1'b0, NO_LEAD},
      '{16'h0064, 16'hC000, 16'h4000, 12'h155, 1'b0, NO_LEAD},
      '{16'h8001, 16'h7FFF, 16'h7FFF, 12'h010, 1'b0, NO_LEAD},
      // minus sign, five digits and the largest scale: the widest offsets
      '{16'h8000, 16'h0000, 16'h0000, 12'hFFF, 1'b0, NO_LEAD},
      '{16'h7FFF, 16'h8000, 16'h7FFF, 12'hFFF, 1'b0, NO_LEAD},
      '{16'h0007, 16'h7FFF, 16'h8000, 12'h000, 1'b0, NO_LEAD},
      '{16'h8000, 16'h7FFF, 16'h7FFF, 12'hFFF, 1'b0, NO_LEAD}
   };

   logic clock;
   logic reset;

   ssns_req_if req_bus ();
   ssns_rsp_if rsp_bus ();

   seven_segment_number_strokes_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   stroke_type pending_strokes [$];  // strokes the block still owes, oldest first
   word_type   offered_words [$];    // words put on the bus, not yet taken
   int         mismatch_count;
   int         hold_requests;        // bumped by the source to stall the sink
   logic       steady_phase;         // no idling on either side while set

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Snap one endpoint: origin plus k units at this scale, rounded half up,
   // clamped to the coordinate range.
   function automatic logic [CW-1:0] snap_coord(input logic [CW-1:0] origin,
                                                input int units,
                                                input logic [SCALE_BITS-1:0] sc);
      int p;
      p = int'($signed(origin)) + ((units * int'(sc) + 8) >>> 4);
      if (p > COORD_MAX) p = COORD_MAX;
      if (p < COORD_MIN) p = COORD_MIN;
      return p[CW-1:0];
   endfunction

   // Endpoints of one segment inside its cell, in glyph units
   function automatic void segment_ends(input segment_type g, output int x0, output int y0,
                                        output int x1, output int y1);
      case (g)
         SEG_TOP:         begin x0 = 0;          y0 = CELL_TOP; x1 = CELL_WIDTH; y1 = CELL_TOP; end
         SEG_UPPER_LEFT:  begin x0 = 0;          y0 = CELL_TOP; x1 = 0;          y1 = CELL_MID; end
         SEG_UPPER_RIGHT: begin x0 = CELL_WIDTH; y0 = CELL_TOP; x1 = CELL_WIDTH; y1 = CELL_MID; end
         SEG_MIDDLE:      begin x0 = 0;          y0 = CELL_MID; x1 = CELL_WIDTH; y1 = CELL_MID; end
         SEG_LOWER_LEFT:  begin x0 = 0;          y0 = CELL_MID; x1 = 0;          y1 = 0;        end
         SEG_LOWER_RIGHT: begin x0 = CELL_WIDTH; y0 = CELL_MID; x1 = CELL_WIDTH; y1 = 0;        end
         default:         begin x0 = 0;          y0 = 0;        x1 = CELL_WIDTH; y1 = 0;        end
      endcase
   endfunction

   function automatic void queue_stroke(input logic [CW-1:0] ox, input logic [CW-1:0] oy,
                                        input logic [SCALE_BITS-1:0] sc,
                                        input int x0, input int y0, input int x1, input int y1);
      stroke_type s;
      s.sx   = snap_coord(ox, x0, sc);
      s.sy   = snap_coord(oy, y0, sc);
      s.ex   = snap_coord(ox, x1, sc);
      s.ey   = snap_coord(oy, y1, sc);
      s.last = 1'b0;
      pending_strokes.insert(pending_strokes.size(), s);
   endfunction

   // Work out every stroke one number draws and append them in order
   function automatic void draw_number_strokes(input logic [VW-1:0] value,
                                               input logic [CW-1:0] ox,
                                               input logic [CW-1:0] oy,
                                               input logic [SCALE_BITS-1:0] sc);
      int digits [12];
      int digit_count;
      int mag;
      int pen;
      int x0, y0, x1, y1;
      mag = int'($signed(value));
      if (mag < 0) mag = -mag;
      digit_count = 0;
      do begin
         digits[digit_count] = mag % 10;
         mag = mag / 10;
         digit_count++;
      end while (mag != 0);
      pen = 0;
      if (value[VW-1]) begin
         queue_stroke(ox, oy, sc, 0, BAR_HEIGHT, BAR_LENGTH, BAR_HEIGHT);
         pen = PEN_AFTER_MINUS;
      end
      for (int d = digit_count - 1; d >= 0; d--) begin
         for (int g = SEG_TOP; g <= SEG_BOTTOM; g++) begin
            if (LIT_SEGMENTS[digits[d]][g]) begin
               segment_ends(segment_type'(g), x0, y0, x1, y1);
               queue_stroke(ox, oy, sc, pen + x0, y0, pen + x1, y1);
            end
         end
         pen += PEN_PER_DIGIT;
      end
      pending_strokes[pending_strokes.size() - 1].last = 1'b1;
   endfunction

   function automatic void report_mismatch(input string what, input stroke_type want,
                                           input stroke_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t mismatch (%s): expected sx=%h sy=%h ex=%h ey=%h last=%b,",
                  $realtime, what, want.sx, want.sy, want.ex, want.ey, want.last,
                  " got sx=%h sy=%h ex=%h ey=%h last=%b",
                  got.sx, got.sy, got.ex, got.ey, got.last);
   endfunction

   // Random word: values spread over every digit count and both signs,
   // origins now and then near the limits, scales mostly small.
   function automatic word_type random_word();
      word_type w;
      int       pick;
      w = '0;
      pick = $urandom_range(0, 4);
      case (pick)
         0: w.value = VW'($urandom);
         1: w.value = VW'($urandom_range(0, 9));
         2: w.value = VW'($urandom_range(0, 999));
         3: w.value = VW'($urandom_range(0, 32767));
         default: begin
            case ($urandom_range(0, 3))
               0: w.value = {1'b1, {(VW - 1){1'b0}}};
               1: w.value = {1'b0, {(VW - 1){1'b1}}};
               2: w.value = '0;
               default: w.value = '1;
            endcase
         end
      endcase
      if (pick >= 1 && pick <= 3 && $urandom_range(0, 1) == 1) w.value = -w.value;
      case ($urandom_range(0, 7))
         6: begin
            w.origin_x = CW'(COORD_MAX - int'($urandom_range(0, 2047)));
            w.origin_y = CW'(COORD_MAX - int'($urandom_range(0, 2047)));
         end
         7: begin
            w.origin_x = CW'(COORD_MIN + int'($urandom_range(0, 2047)));
            w.origin_y = CW'(COORD_MIN + int'($urandom_range(0, 2047)));
         end
         default: begin
            w.origin_x = CW'($urandom);
            w.origin_y = CW'($urandom);
         end
      endcase
      case ($urandom_range(0, 9))
         0, 1: w.scale = SCALE_BITS'($urandom);
         2:    w.scale = $urandom_range(0, 1) ? '1 : '0;
         default: w.scale = SCALE_BITS'($urandom_range(0, 511));
      endcase
      return w;
   endfunction

   // Offer one word and hold it until the block takes it. Now and then
   // drop valid first, with junk on the payload.
   task automatic offer_word(input word_type w);
      if (!steady_phase && $urandom_range(0, 99) < 26) begin
         req_bus.valid    <= 1'b0;
         req_bus.value    <= VW'($urandom);
         req_bus.origin_x <= CW'($urandom);
         req_bus.origin_y <= CW'($urandom);
         req_bus.scale    <= SCALE_BITS'($urandom);
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      offered_words.insert(offered_words.size(), w);
      req_bus.valid    <= 1'b1;
      req_bus.value    <= w.value;
      req_bus.origin_x <= w.origin_x;
      req_bus.origin_y <= w.origin_y;
      req_bus.scale    <= w.scale;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Drop valid and wait until the block owes nothing more
   task automatic drain_strokes();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_strokes.size() != 0) @(posedge clock);
   endtask

   // Request side: reset, directed table, then random words
   initial begin : word_source
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.value    <= '0;
      req_bus.origin_x <= '0;
      req_bus.origin_y <= '0;
      req_bus.scale    <= '0;
      steady_phase     <= 1'b0;
      hold_requests    <= 0;
      mismatch_count    = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++) offer_word(DIRECTED_WORDS[i]);

      for (int k = 0; k < RANDOM_WORDS; k++) begin
         // Stall the sink for a long stretch while words keep coming, so
         // the block backs up all the way to its input.
         if (k == 15) hold_requests <= hold_requests + 1;
         // Hold off the source until every owed stroke is out
         if (k == 45) drain_strokes();
         // Run a stretch with both sides at full rate
         steady_phase <= (k >= 70 && k < 110);
         offer_word(random_word());
      end

      drain_strokes();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_strokes.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Result side: take strokes at random, honor long hold requests
   initial begin : stroke_sink
      int holds_served;
      holds_served = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            holds_served++;
            rsp_bus.ready <= 1'b0;
            repeat (SINK_HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_bus.ready <= !reset && (steady_phase || $urandom_range(0, 99) >= 26);
         end
      end
   end

   // Predict strokes for each word the block accepts. Where the table gives
   // a typed first stroke, check against it instead of the prediction.
   always @(posedge clock) begin : accept_monitor
      word_type w;
      int       first;
      if (!reset && req_bus.valid && req_bus.ready) begin
         w = offered_words.pop_front();
         first = pending_strokes.size();
         draw_number_strokes(req_bus.value, req_bus.origin_x, req_bus.origin_y,
                             req_bus.scale);
         if (w.has_lead) pending_strokes[first] = w.lead;
      end
   end

   // Compare each stroke taken with the oldest one owed
   always @(posedge clock) begin : stroke_checker
      stroke_type want;
      stroke_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.sx   = rsp_bus.start_x;
         got.sy   = rsp_bus.start_y;
         got.ex   = rsp_bus.end_x;
         got.ey   = rsp_bus.end_y;
         got.last = rsp_bus.last;
         if (pending_strokes.size() == 0) begin
            report_mismatch("stroke with none owed", NO_LEAD, got);
         end else begin
            want = pending_strokes.pop_front();
            if (got.sx !== want.sx || got.sy !== want.sy || got.ex !== want.ex ||
                got.ey !== want.ey || got.last !== want.last)
               report_mismatch("stroke fields", want, got);
         end
      end
   end

   // Bound the run well past the slowest legal schedule
   initial begin : watchdog
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

`default_nettype wire
